// ===== hdl/assert_macros.svh =====
// Assertion macros shared by the checker files of this block.
// Depends on nothing; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Generic clocked assertion with an active-low reset disable.
`define ASSERT_CLK(label, clk, rstn, prop) \
    label: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
        else $error("%m: assertion failed");

// Shorthand for the block clock and reset.
`define ASSERT_ACLK(label, prop) `ASSERT_CLK(label, aclk, aresetn, prop)

`endif

// ===== hdl/mrva_pkg.sv =====
// Shared types and constants for the mesh route and VC allocation core.
// Depends on nothing; every module of the block imports it.
`default_nettype none

package mrva_pkg;

    // Router geometry.
    localparam int NUM_VC      = 2;
    localparam int NUM_PORTS   = 5;
    localparam int ENTRY_COUNT = NUM_PORTS * NUM_VC;
    localparam int ENTRY_W     = $clog2(ENTRY_COUNT);
    localparam int VC_W        = (NUM_VC > 1) ? $clog2(NUM_VC) : 1;

    // Field widths.
    localparam int PORT_W     = 3;
    localparam int VCSEL_W    = 3;
    localparam int NODE_W     = 8;
    localparam int MESHW_W    = 5;
    localparam int AGE_W      = 32;
    localparam int CFG_DATA_W = 8;
    localparam int CFG_IDX_W  = 1;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_NODE_ID    = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MESH_WIDTH = 1'd1;

    // Port numbering.
    localparam int PORT_LOCAL = 0;
    localparam int PORT_NORTH = 1;
    localparam int PORT_SOUTH = 2;
    localparam int PORT_WEST  = 3;
    localparam int PORT_EAST  = 4;

    typedef logic [NUM_PORTS-1:0] port_mask_t;

    // Request to the shared divider.
    typedef struct packed {
        logic               start;
        logic [NODE_W-1:0]  dividend;
        logic [MESHW_W-1:0] divisor;
    } div_req_t;

    // Response of the shared divider.
    typedef struct packed {
        logic               done;
        logic [NODE_W-1:0]  quot;
        logic [MESHW_W-1:0] rem;
    } div_rsp_t;

    // Coordinates of this router and of the destination.
    typedef struct packed {
        logic               at_dest;
        logic [MESHW_W-1:0] xs;
        logic [MESHW_W-1:0] xd;
        logic [NODE_W-1:0]  ys;
        logic [NODE_W-1:0]  yd;
    } coord_t;

endpackage

`default_nettype wire

// ===== hdl/mesh_route_and_vc_allocation_core.sv =====
// Top level of the mesh route computation and VC allocation core.
// Depends on mrva_pkg, mrva_div and mrva_mask.
//
// Usage:
//   Configuration: cfg_wr_en with cfg_index selects node_id (index 0) or mesh_width
//   (index 1); the write takes effect at that clock edge. Write only while idle.
//   Input channel (s_*): valid/ready. A route item (kind 0) stores the routing masks for
//   an input port and VC; an allocate item (kind 1) picks the oldest pending entry that
//   can use the requested output port and VC.
//   Result channel (m_*): valid/ready, one result item per input item, held in an output
//   register, so the next item can be accepted while a result waits.
//   Sequence: a route item makes two passes through the 8-step shared divider; an
//   allocate item runs the ten-entry scan through one age comparator.
//   s_ready is high only while the sequencer is idle; one item is in work at a time.
//   Stall: when m_ready is low, a finished item waits in the sequencer until the output
//   register frees up; nothing is lost.
//   Reset: aresetn low clears all pending marks, the handshakes, node_id to 0 and
//   mesh_width to 4. Entry ages and masks need no reset.
`default_nettype none

module mesh_route_and_vc_allocation_core
    import mrva_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
    input  wire logic                  s_valid,
    output logic                       s_ready,
    input  wire logic                  s_kind,
    input  wire logic [PORT_W-1:0]     s_port_sel,
    input  wire logic [VCSEL_W-1:0]    s_vc_sel,
    input  wire logic [NODE_W-1:0]     s_dest_node,
    input  wire logic [AGE_W-1:0]      s_age_stamp,
    output logic                       m_valid,
    input  wire logic                  m_ready,
    output logic [NUM_PORTS-1:0]       m_adaptive_mask,
    output logic [NUM_PORTS-1:0]       m_escape_mask,
    output logic                       m_granted,
    output logic [PORT_W-1:0]          m_winner_port,
    output logic [VCSEL_W-1:0]         m_winner_vc
);

    localparam logic [2:0] ST_IDLE     = 3'd0;
    localparam logic [2:0] ST_DIV_NODE = 3'd1;
    localparam logic [2:0] ST_DIV_DEST = 3'd2;
    localparam logic [2:0] ST_MASK     = 3'd3;
    localparam logic [2:0] ST_SCAN     = 3'd4;
    localparam logic [2:0] ST_FINISH   = 3'd5;

    localparam logic [PORT_W-1:0] LAST_PORT = PORT_W'(NUM_PORTS - 1);
    localparam logic [VC_W-1:0]   LAST_VC   = VC_W'(NUM_VC - 1);

    // Configuration registers.
    logic [NODE_W-1:0]  node_id_reg;
    logic [MESHW_W-1:0] mesh_width_reg;

    // Sequencer and captured item.
    logic [2:0]         state_reg;
    logic               kind_reg;
    logic [PORT_W-1:0]  port_reg;
    logic [VCSEL_W-1:0] vc_reg;
    logic [NODE_W-1:0]  dest_reg;
    logic [AGE_W-1:0]   age_reg;

    // Coordinates and route result.
    logic [MESHW_W-1:0] xs_reg;
    logic [MESHW_W-1:0] xd_reg;
    logic [NODE_W-1:0]  ys_reg;
    logic [NODE_W-1:0]  yd_reg;
    port_mask_t         res_adapt_reg;
    port_mask_t         res_esc_reg;

    // Allocation scan.
    logic [PORT_W-1:0] scan_port_reg;
    logic [VC_W-1:0]   scan_vc_reg;
    logic              found_reg;
    logic [AGE_W-1:0]  best_age_reg;
    logic [PORT_W-1:0] best_port_reg;
    logic [VC_W-1:0]   best_vc_reg;

    // Entry store, one entry per input port and VC.
    logic [ENTRY_COUNT-1:0] pending_reg;
    logic [AGE_W-1:0]       age_mem   [ENTRY_COUNT];
    port_mask_t             adapt_mem [ENTRY_COUNT];
    port_mask_t             esc_mem   [ENTRY_COUNT];

    // Output register.
    logic               m_valid_reg;
    port_mask_t         m_adapt_reg;
    port_mask_t         m_esc_reg;
    logic               m_granted_reg;
    logic [PORT_W-1:0]  m_port_reg;
    logic [VCSEL_W-1:0] m_vc_reg;

    div_req_t   div_req;
    div_rsp_t   div_rsp;
    coord_t     coord;
    port_mask_t mask_adapt;
    port_mask_t mask_esc;

    logic               accept;
    logic               out_load;
    logic               wr_ok;
    logic [ENTRY_W-1:0] wr_idx;
    logic [ENTRY_W-1:0] scan_idx;
    logic [ENTRY_W-1:0] best_idx;
    logic               escape_class;
    logic               port_ok;
    port_mask_t         scan_mask;
    logic               scan_hit;
    logic               scan_older;
    logic               scan_last;

    assign s_ready  = (state_reg == ST_IDLE);
    assign accept   = s_valid && s_ready;
    assign out_load = (state_reg == ST_FINISH) && (!m_valid_reg || m_ready);

    // Shared divider requests: node first, then destination.
    always_comb begin
        div_req.start    = (accept && !s_kind) || ((state_reg == ST_DIV_NODE) && div_rsp.done);
        div_req.dividend = (state_reg == ST_IDLE) ? node_id_reg : dest_reg;
        div_req.divisor  = mesh_width_reg;
    end

    mrva_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    always_comb begin
        coord.at_dest = (dest_reg == node_id_reg);
        coord.xs      = xs_reg;
        coord.xd      = xd_reg;
        coord.ys      = ys_reg;
        coord.yd      = yd_reg;
    end

    mrva_mask u_mask (
        .c        (coord),
        .adaptive (mask_adapt),
        .escape   (mask_esc)
    );

    // Entry addressing and the per-cycle scan compare.
    always_comb begin
        wr_ok        = (port_reg < PORT_W'(NUM_PORTS)) &&
                       ({1'b0, vc_reg} < (VCSEL_W + 1)'(NUM_VC));
        wr_idx       = ENTRY_W'(port_reg * NUM_VC + vc_reg);
        scan_idx     = ENTRY_W'(scan_port_reg * NUM_VC + scan_vc_reg);
        best_idx     = ENTRY_W'(best_port_reg * NUM_VC + best_vc_reg);
        escape_class = ({1'b0, vc_reg} >= (VCSEL_W + 1)'(NUM_VC - 1));
        port_ok      = (port_reg < PORT_W'(NUM_PORTS));
        scan_mask    = escape_class ? esc_mem[scan_idx] : adapt_mem[scan_idx];
        scan_hit     = pending_reg[scan_idx] && (scan_port_reg != port_reg) &&
                       port_ok && scan_mask[port_reg];
        scan_older   = !found_reg || (age_mem[scan_idx] < best_age_reg);
        scan_last    = (scan_port_reg == LAST_PORT) && (scan_vc_reg == LAST_VC);
    end

    // Configuration writes.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            node_id_reg    <= '0;
            mesh_width_reg <= MESHW_W'(4);
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_NODE_ID:    node_id_reg    <= cfg_wdata[NODE_W-1:0];
                CFG_MESH_WIDTH: mesh_width_reg <= cfg_wdata[MESHW_W-1:0];
                default:        ;
            endcase
        end
    end

    // Sequencer.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            unique case (state_reg)
                ST_IDLE: begin
                    if (accept) begin
                        state_reg <= s_kind ? ST_SCAN : ST_DIV_NODE;
                    end
                end
                ST_DIV_NODE: begin
                    if (div_rsp.done) begin
                        state_reg <= ST_DIV_DEST;
                    end
                end
                ST_DIV_DEST: begin
                    if (div_rsp.done) begin
                        state_reg <= ST_MASK;
                    end
                end
                ST_MASK: begin
                    state_reg <= ST_FINISH;
                end
                ST_SCAN: begin
                    if (scan_last) begin
                        state_reg <= ST_FINISH;
                    end
                end
                ST_FINISH: begin
                    if (out_load) begin
                        state_reg <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // Item capture, coordinates, route result and scan datapath.
    always_ff @(posedge aclk) begin
        if (accept) begin
            kind_reg      <= s_kind;
            port_reg      <= s_port_sel;
            vc_reg        <= s_vc_sel;
            dest_reg      <= s_dest_node;
            age_reg       <= s_age_stamp;
            scan_port_reg <= '0;
            scan_vc_reg   <= '0;
            found_reg     <= 1'b0;
            best_age_reg  <= '0;
            best_port_reg <= '0;
            best_vc_reg   <= '0;
        end
        if ((state_reg == ST_DIV_NODE) && div_rsp.done) begin
            xs_reg <= div_rsp.rem;
            ys_reg <= div_rsp.quot;
        end
        if ((state_reg == ST_DIV_DEST) && div_rsp.done) begin
            xd_reg <= div_rsp.rem;
            yd_reg <= div_rsp.quot;
        end
        if (state_reg == ST_MASK) begin
            res_adapt_reg <= mask_adapt;
            res_esc_reg   <= mask_esc;
        end
        if (state_reg == ST_SCAN) begin
            // Strictly older wins, so ties keep the first entry in scan order.
            if (scan_hit && scan_older) begin
                found_reg     <= 1'b1;
                best_age_reg  <= age_mem[scan_idx];
                best_port_reg <= scan_port_reg;
                best_vc_reg   <= scan_vc_reg;
            end
            if (scan_vc_reg == LAST_VC) begin
                scan_vc_reg   <= '0;
                scan_port_reg <= scan_port_reg + 1'b1;
            end else begin
                scan_vc_reg <= scan_vc_reg + 1'b1;
            end
        end
    end

    // Entry payload writes on a route item to a valid port and VC.
    always_ff @(posedge aclk) begin
        if ((state_reg == ST_MASK) && wr_ok) begin
            age_mem[wr_idx]   <= age_reg;
            adapt_mem[wr_idx] <= mask_adapt;
            esc_mem[wr_idx]   <= mask_esc;
        end
    end

    // Pending marks: set by a route item, cleared for the allocation winner.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pending_reg <= '0;
        end else begin
            if ((state_reg == ST_MASK) && wr_ok) begin
                pending_reg[wr_idx] <= 1'b1;
            end
            if (out_load && kind_reg && found_reg) begin
                pending_reg[best_idx] <= 1'b0;
            end
        end
    end

    // Output register handshake.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    // Output payload.
    always_ff @(posedge aclk) begin
        if (out_load) begin
            if (kind_reg) begin
                m_adapt_reg   <= '0;
                m_esc_reg     <= '0;
                m_granted_reg <= found_reg;
                m_port_reg    <= found_reg ? best_port_reg : '0;
                m_vc_reg      <= found_reg ? VCSEL_W'(best_vc_reg) : '0;
            end else begin
                m_adapt_reg   <= res_adapt_reg;
                m_esc_reg     <= res_esc_reg;
                m_granted_reg <= 1'b0;
                m_port_reg    <= '0;
                m_vc_reg      <= '0;
            end
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_adaptive_mask = m_adapt_reg;
    assign m_escape_mask   = m_esc_reg;
    assign m_granted       = m_granted_reg;
    assign m_winner_port   = m_port_reg;
    assign m_winner_vc     = m_vc_reg;

endmodule

`default_nettype wire

// ===== hdl/mrva_div.sv =====
// Iterative restoring divider: node number by mesh width, one quotient bit a cycle.
// Depends on mrva_pkg.
`default_nettype none

module mrva_div
    import mrva_pkg::*;
(
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire div_req_t req,
    output div_rsp_t      rsp
);

    localparam int STEP_W = $clog2(NODE_W);
    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(NODE_W - 1);

    logic              busy_reg;
    logic              done_reg;
    logic [STEP_W-1:0] cnt_reg;
    logic [NODE_W-1:0] quot_reg;
    logic [MESHW_W-1:0] rem_reg;
    logic [MESHW_W-1:0] div_reg;

    logic [MESHW_W:0] trial;
    logic [MESHW_W:0] diff;
    logic             fits;

    // One restoring step: bring down the next dividend bit and try a subtract.
    always_comb begin
        trial = {rem_reg, quot_reg[NODE_W-1]};
        diff  = trial - {1'b0, div_reg};
        fits  = (trial >= {1'b0, div_reg});
    end

    // Control: step counter and done pulse.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (req.start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == LAST_STEP) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Datapath: a divisor of zero is taken as one.
    always_ff @(posedge aclk) begin
        if (req.start) begin
            quot_reg <= req.dividend;
            rem_reg  <= '0;
            div_reg  <= (req.divisor == '0) ? MESHW_W'(1) : req.divisor;
        end else if (busy_reg) begin
            quot_reg <= {quot_reg[NODE_W-2:0], fits};
            rem_reg  <= fits ? diff[MESHW_W-1:0] : trial[MESHW_W-1:0];
        end
    end

    assign rsp.done = done_reg;
    assign rsp.quot = quot_reg;
    assign rsp.rem  = rem_reg;

endmodule

`default_nettype wire

// ===== hdl/mrva_mask.sv =====
// Minimal adaptive and XY escape port masks from source and destination coordinates.
// Depends on mrva_pkg.
`default_nettype none

module mrva_mask
    import mrva_pkg::*;
(
    input  wire coord_t c,
    output port_mask_t  adaptive,
    output port_mask_t  escape
);

    always_comb begin
        adaptive = '0;
        escape   = '0;
        if (c.at_dest) begin
            adaptive[PORT_LOCAL] = 1'b1;
            escape[PORT_LOCAL]   = 1'b1;
        end else begin
            // Every minimal direction.
            if (c.xs > c.xd) begin
                adaptive[PORT_WEST] = 1'b1;
            end else if (c.xs < c.xd) begin
                adaptive[PORT_EAST] = 1'b1;
            end
            if (c.ys > c.yd) begin
                adaptive[PORT_NORTH] = 1'b1;
            end else if (c.ys < c.yd) begin
                adaptive[PORT_SOUTH] = 1'b1;
            end
            // Dimension order: x first, then y.
            priority if (c.xs > c.xd) begin
                escape[PORT_WEST] = 1'b1;
            end else if (c.xs < c.xd) begin
                escape[PORT_EAST] = 1'b1;
            end else if (c.ys > c.yd) begin
                escape[PORT_NORTH] = 1'b1;
            end else if (c.ys < c.yd) begin
                escape[PORT_SOUTH] = 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

// ===== hdl/mrva_checker.sv =====
// Port-level checker for the mesh route and VC allocation core, bound to the top level.
// Depends on mrva_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module mrva_checker
    import mrva_pkg::*;
(
    input wire logic                 aclk,
    input wire logic                 aresetn,
    input wire logic                 s_valid,
    input wire logic                 s_ready,
    input wire logic                 m_valid,
    input wire logic                 m_ready,
    input wire logic [NUM_PORTS-1:0] m_adaptive_mask,
    input wire logic [NUM_PORTS-1:0] m_escape_mask,
    input wire logic                 m_granted,
    input wire logic [PORT_W-1:0]    m_winner_port,
    input wire logic [VCSEL_W-1:0]   m_winner_vc
);

    // A stalled result item stays offered.
    `ASSERT_ACLK(a_out_hold, m_valid && !m_ready |=> m_valid)

    // One item at a time: the block is busy right after it takes an item.
    `ASSERT_ACLK(a_busy_after_accept, s_valid && s_ready |=> !s_ready)

    // A grant comes from an allocate item, which carries no route masks.
    `ASSERT_ACLK(a_grant_no_masks, m_valid && m_granted |-> (m_adaptive_mask == '0) && (m_escape_mask == '0))

    // Without a grant the winner fields read zero.
    `ASSERT_ACLK(a_no_grant_zero, m_valid && !m_granted |-> (m_winner_port == '0) && (m_winner_vc == '0))

    // A winner always sits on a real input port.
    `ASSERT_ACLK(a_winner_port_ok, m_valid && m_granted |-> m_winner_port < PORT_W'(NUM_PORTS))

endmodule

bind mesh_route_and_vc_allocation_core mrva_checker u_mrva_checker (.*);

`default_nettype wire

// ===== bench/mesh_route_and_vc_allocation_core_test.sv =====
`timescale 1ns / 1ps
// Self-checking bench for mesh_route_and_vc_allocation_core: route and allocate items
// are checked against an in-bench predictor across several router configurations.
// Depends on mrva_pkg and the core RTL.

module mesh_route_and_vc_allocation_core_test;
    import mrva_pkg::*;

    localparam int IDLE_PCT      = 27;
    localparam int SETTLE_CYCLES = 40;
    localparam int CALM_FIRST    = 12000;
    localparam int CALM_LAST     = 20000;
    localparam int REPORT_LIMIT  = 10;
    localparam int PHASE_ITEMS   = 220;

    // Item kinds.
    localparam logic KIND_ROUTE = 1'b0;
    localparam logic KIND_ALLOC = 1'b1;

    typedef struct packed {
        logic               kind;
        logic [PORT_W-1:0]  port_sel;
        logic [VCSEL_W-1:0] vc_sel;
        logic [NODE_W-1:0]  dest_node;
        logic [AGE_W-1:0]   age_stamp;
    } flit_req_t;

    typedef struct packed {
        port_mask_t         adaptive;
        port_mask_t         escape;
        logic               granted;
        logic [PORT_W-1:0]  winner_port;
        logic [VCSEL_W-1:0] winner_vc;
    } route_grant_t;

    // Block ports, all known from time zero.
    logic                  aclk;
    logic                  aresetn   = 1'b0;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;
    logic                  s_valid     = 1'b0;
    logic                  s_ready;
    logic                  s_kind      = 1'b0;
    logic [PORT_W-1:0]     s_port_sel  = '0;
    logic [VCSEL_W-1:0]    s_vc_sel    = '0;
    logic [NODE_W-1:0]     s_dest_node = '0;
    logic [AGE_W-1:0]      s_age_stamp = '0;
    logic                  m_valid;
    logic                  m_ready     = 1'b0;
    port_mask_t            m_adaptive_mask;
    port_mask_t            m_escape_mask;
    logic                  m_granted;
    logic [PORT_W-1:0]     m_winner_port;
    logic [VCSEL_W-1:0]    m_winner_vc;

    // Predictor copy of the configuration and the entry buffer.
    logic [NODE_W-1:0]  my_node  = 8'd0;
    logic [MESHW_W-1:0] my_width = 5'd4;
    bit                 entry_pending [ENTRY_COUNT];
    logic [AGE_W-1:0]   entry_age     [ENTRY_COUNT];
    port_mask_t         adaptive_ports[ENTRY_COUNT];
    port_mask_t         escape_ports  [ENTRY_COUNT];

    flit_req_t    pending_flits[$];
    route_grant_t expected_grants[$];
    flit_req_t    driven_flit;
    flit_req_t    next_flit;
    route_grant_t want;
    int           fail_count  = 0;
    int           cycle_count = 0;
    logic         calm;

    mesh_route_and_vc_allocation_core u_top (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_index       (cfg_index),
        .cfg_wdata       (cfg_wdata),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_kind          (s_kind),
        .s_port_sel      (s_port_sel),
        .s_vc_sel        (s_vc_sel),
        .s_dest_node     (s_dest_node),
        .s_age_stamp     (s_age_stamp),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_adaptive_mask (m_adaptive_mask),
        .m_escape_mask   (m_escape_mask),
        .m_granted       (m_granted),
        .m_winner_port   (m_winner_port),
        .m_winner_vc     (m_winner_vc)
    );

    // Clock generation.
    always begin
        aclk = 1'b1;
        #5;
        aclk = 1'b0;
        #5;
    end

    // Cycle count and the window in which neither side idles.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
    end
    assign calm = (cycle_count >= CALM_FIRST) && (cycle_count < CALM_LAST);

    function automatic bit roll_idle();
        return !calm && ($urandom_range(0, 99) < IDLE_PCT);
    endfunction

    // Minimal adaptive and XY escape masks toward dest from this router.
    function automatic void route_masks(input logic [NODE_W-1:0] dest,
                                        output port_mask_t adaptive,
                                        output port_mask_t escape);
        int w, xs, ys, xd, yd;
        w  = (my_width == 0) ? 1 : int'(my_width);
        xs = int'(my_node) % w;
        ys = int'(my_node) / w;
        xd = int'(dest) % w;
        yd = int'(dest) / w;
        adaptive = '0;
        escape   = '0;
        if (dest == my_node) begin
            adaptive[PORT_LOCAL] = 1'b1;
            escape[PORT_LOCAL]   = 1'b1;
            return;
        end
        if (xs > xd) adaptive[PORT_WEST] = 1'b1;
        else if (xs < xd) adaptive[PORT_EAST] = 1'b1;
        if (ys > yd) adaptive[PORT_NORTH] = 1'b1;
        else if (ys < yd) adaptive[PORT_SOUTH] = 1'b1;
        // Dimension order: x first, then y.
        if (xs > xd) escape[PORT_WEST] = 1'b1;
        else if (xs < xd) escape[PORT_EAST] = 1'b1;
        else if (ys > yd) escape[PORT_NORTH] = 1'b1;
        else if (ys < yd) escape[PORT_SOUTH] = 1'b1;
    endfunction

    // Expected result of one accepted item; updates the predictor's entry buffer.
    function automatic route_grant_t predict_grant(input flit_req_t f);
        route_grant_t r;
        port_mask_t   a, e, m;
        bit           use_escape;
        int           idx, best;
        r = '0;
        if (f.kind == KIND_ROUTE) begin
            route_masks(f.dest_node, a, e);
            if (f.port_sel < NUM_PORTS && f.vc_sel < NUM_VC) begin
                idx = int'(f.port_sel) * NUM_VC + int'(f.vc_sel);
                entry_pending[idx]  = 1'b1;
                entry_age[idx]      = f.age_stamp;
                adaptive_ports[idx] = a;
                escape_ports[idx]   = e;
            end
            r.adaptive = a;
            r.escape   = e;
        end else begin
            // The last VC and anything above it form the escape class.
            use_escape = (f.vc_sel >= NUM_VC - 1);
            best = -1;
            if (f.port_sel < NUM_PORTS) begin
                for (int p = 0; p < NUM_PORTS; p++) begin
                    if (p == f.port_sel) continue;
                    for (int v = 0; v < NUM_VC; v++) begin
                        idx = p * NUM_VC + v;
                        m = use_escape ? escape_ports[idx] : adaptive_ports[idx];
                        if (entry_pending[idx] && m[f.port_sel] &&
                            (best < 0 || entry_age[idx] < entry_age[best]))
                            best = idx;
                    end
                end
            end
            if (best >= 0) begin
                entry_pending[best] = 1'b0;
                r.granted     = 1'b1;
                r.winner_port = PORT_W'(best / NUM_VC);
                r.winner_vc   = VCSEL_W'(best % NUM_VC);
            end
        end
        return r;
    endfunction

    // Input driver: predicts each accepted item and presents the next one.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!(s_valid && !s_ready)) begin
            if (s_valid) begin
                expected_grants.insert(expected_grants.size(), predict_grant(driven_flit));
            end
            if (pending_flits.size() > 0 && !roll_idle()) begin
                next_flit    = pending_flits.pop_front();
                driven_flit <= next_flit;
                s_kind      <= next_flit.kind;
                s_port_sel  <= next_flit.port_sel;
                s_vc_sel    <= next_flit.vc_sel;
                s_dest_node <= next_flit.dest_node;
                s_age_stamp <= next_flit.age_stamp;
                s_valid     <= 1'b1;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // Result monitor: compares each accepted result with the oldest expectation.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (expected_grants.size() == 0) begin
                    fail_count++;
                    if (fail_count <= REPORT_LIMIT)
                        $display("%0t: result with nothing expected: adapt=%h esc=%h gnt=%0d",
                                 $realtime, m_adaptive_mask, m_escape_mask, m_granted);
                end else begin
                    want = expected_grants.pop_front();
                    if (m_adaptive_mask !== want.adaptive || m_escape_mask !== want.escape ||
                        m_granted !== want.granted || m_winner_port !== want.winner_port ||
                        m_winner_vc !== want.winner_vc) begin
                        fail_count++;
                        if (fail_count <= REPORT_LIMIT)
                            $display({"%0t: mismatch: got adapt=%h esc=%h gnt=%0d port=%0d ",
                                      "vc=%0d, expected adapt=%h esc=%h gnt=%0d port=%0d vc=%0d"},
                                     $realtime, m_adaptive_mask, m_escape_mask, m_granted,
                                     m_winner_port, m_winner_vc, want.adaptive, want.escape,
                                     want.granted, want.winner_port, want.winner_vc);
                    end
                end
            end
            m_ready <= !roll_idle();
        end
    end

    task automatic add_flit(input logic kind, input int port, input int vc,
                            input int dest, input logic [AGE_W-1:0] age);
        flit_req_t f;
        f.kind      = kind;
        f.port_sel  = PORT_W'(port);
        f.vc_sel    = VCSEL_W'(vc);
        f.dest_node = NODE_W'(dest);
        f.age_stamp = age;
        pending_flits.insert(pending_flits.size(), f);
    endtask

    // Register write; the predictor takes the same truncation as the block.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        if (idx == CFG_NODE_ID) my_node = data[NODE_W-1:0];
        else if (idx == CFG_MESH_WIDTH) my_width = data[MESHW_W-1:0];
    endtask

    // Wait until every item is accepted and every result has arrived.
    task automatic drain();
        while (pending_flits.size() != 0 || s_valid || expected_grants.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // Destinations favor this node and its close neighborhood.
    function automatic int pick_dest();
        int w;
        w = (my_width == 0) ? 1 : int'(my_width);
        case ($urandom_range(0, 9))
            0:       return int'(my_node);
            1, 2, 3: return (int'(my_node) + $urandom_range(0, 4) * w
                             + $urandom_range(0, 4) - 2 - 2 * w) & 8'hFF;
            default: return $urandom_range(0, 255);
        endcase
    endfunction

    function automatic logic [AGE_W-1:0] pick_age();
        case ($urandom_range(0, 9))
            0:          return '0;
            1:          return '1;
            2, 3, 4, 5: return AGE_W'($urandom_range(0, 15));
            default:    return $urandom;
        endcase
    endfunction

    // Bursts of routes followed by bursts of allocations, with some malformed items.
    task automatic load_random(input int count);
        int left, burst, port, vc;
        left = count;
        while (left > 0) begin
            burst = $urandom_range(1, 4);
            for (int i = 0; i < burst && left > 0; i++) begin
                port = $urandom_range(0, NUM_PORTS - 1);
                vc   = $urandom_range(0, NUM_VC - 1);
                if ($urandom_range(0, 99) < 12) begin
                    port = $urandom_range(0, 7);
                    vc   = $urandom_range(0, 7);
                end
                add_flit(KIND_ROUTE, port, vc, pick_dest(), pick_age());
                left--;
            end
            burst = $urandom_range(1, 4);
            for (int i = 0; i < burst && left > 0; i++) begin
                port = ($urandom_range(0, 99) < 8) ? $urandom_range(NUM_PORTS, 7)
                                                   : $urandom_range(0, NUM_PORTS - 1);
                vc   = $urandom_range(0, 1) ? 0 : $urandom_range(1, 7);
                add_flit(KIND_ALLOC, port, vc, $urandom_range(0, 255), $urandom);
                left--;
            end
        end
    endtask

    // Run timeout.
    initial begin
        #(5_000_000);
        $display("FAILURE");
        $finish;
    end

    // Main sequence: reset, directed items, then random phases over several settings.
    initial begin
        logic [CFG_DATA_W-1:0] node_list[8];
        logic [CFG_DATA_W-1:0] width_list[8];
        node_list  = '{8'd9, 8'd0, 8'd255, 8'd37, 8'd200, 8'd0, 8'd0, 8'd0};
        width_list = '{8'd4, 8'd0, 8'd16, 8'd1, 8'hFF, 8'd16, 8'd0, 8'd0};
        node_list[6]  = CFG_DATA_W'($urandom_range(0, 255));
        width_list[6] = CFG_DATA_W'($urandom_range(1, 16));
        node_list[7]  = CFG_DATA_W'($urandom_range(0, 255));
        width_list[7] = CFG_DATA_W'($urandom_range(2, 31));

        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed items under the reset configuration: node 0 in a mesh four wide.
        add_flit(KIND_ROUTE, PORT_NORTH, 0, 0, 32'd100);       // arrived: local only
        add_flit(KIND_ALLOC, PORT_LOCAL, 0, 0, 0);             // wins
        add_flit(KIND_ALLOC, PORT_LOCAL, 1, 0, 0);             // no candidate left
        add_flit(KIND_ROUTE, PORT_LOCAL, 0, 255, 32'hFFFF_FFFF);
        add_flit(KIND_ROUTE, PORT_SOUTH, 1, 5, 32'd0);
        add_flit(KIND_ROUTE, PORT_WEST, 0, 4, 32'd0);
        add_flit(KIND_ALLOC, PORT_EAST, 1, 0, 0);              // escape class, oldest wins
        add_flit(KIND_ALLOC, PORT_SOUTH, 0, 0, 0);             // adaptive class
        add_flit(KIND_ROUTE, PORT_EAST, 0, 1, 32'd3);
        add_flit(KIND_ALLOC, PORT_EAST, 0, 0, 0);              // own port is skipped
        add_flit(KIND_ALLOC, PORT_EAST, 0, 0, 0);
        add_flit(KIND_ROUTE, 5, 0, 3, 32'd1);                  // invalid port, not stored
        add_flit(KIND_ROUTE, PORT_NORTH, 2, 7, 32'd1);         // invalid VC, not stored
        add_flit(KIND_ROUTE, 7, 7, 255, 32'd1);
        add_flit(KIND_ROUTE, PORT_NORTH, 1, 2, 32'd50);
        add_flit(KIND_ROUTE, PORT_NORTH, 1, 8, 32'd60);        // overwrites pending entry
        add_flit(KIND_ALLOC, PORT_WEST, 0, 0, 0);
        add_flit(KIND_ALLOC, PORT_SOUTH, 0, 0, 0);
        add_flit(KIND_ALLOC, 5, 0, 0, 0);                      // invalid output port
        add_flit(KIND_ALLOC, 7, 7, 255, 32'hFFFF_FFFF);
        add_flit(KIND_ROUTE, PORT_NORTH, 0, 3, 32'd7);
        add_flit(KIND_ROUTE, PORT_SOUTH, 0, 3, 32'd7);
        add_flit(KIND_ALLOC, PORT_EAST, 7, 0, 0);              // VC above the last: escape, tie goes to scan order
        add_flit(KIND_ALLOC, PORT_EAST, 0, 0, 0);              // the other tied entry
        add_flit(KIND_ALLOC, PORT_EAST, 0, 0, 0);
        drain();

        for (int ph = 0; ph < 8; ph++) begin
            write_reg(CFG_NODE_ID, node_list[ph]);
            write_reg(CFG_MESH_WIDTH, width_list[ph]);
            load_random(PHASE_ITEMS);
            drain();
        end

        if (expected_grants.size() != 0)
            $display("%0d results never arrived", expected_grants.size());
        if (fail_count == 0 && expected_grants.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
